/* rtl/core/b64sc_pkg.sv */
// ----------------------------------------------------------------------------
// Base64 stream codec package
// Shared types, codes and character tables for the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    // Field widths.
    localparam int ByteW  = 8;
    localparam int AccW   = 14;
    localparam int CountW = 4;
    localparam int SymW   = 6;
    localparam int StatW  = 2;

    // Maximum number of results that one input word can cause.
    localparam int MaxRes = 3;

    // Input function codes.
    localparam logic FUNC_DATA   = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // Direction register codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Result status codes.
    localparam logic [StatW-1:0] ST_OK       = 2'd0;
    localparam logic [StatW-1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [StatW-1:0] ST_TRAIL    = 2'd2;

    // The pad character.
    localparam logic [ByteW-1:0] CHAR_PAD = 8'h3D;

    // Input word.
    typedef struct packed {
        logic             func;
        logic [ByteW-1:0] data_byte;
    } t_in;

    // Result word.
    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             has_byte;
        logic             last;
        logic [StatW-1:0] status;
    } t_out;

    // Map a 6-bit symbol to its alphabet character.
    function automatic logic [ByteW-1:0] enc_char(input logic [SymW-1:0] v);
        logic [ByteW-1:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return 8'h41 + w;
        end else if (v < 6'd52) begin
            return 8'h61 + (w - 8'd26);
        end else if (v < 6'd62) begin
            return 8'h30 + (w - 8'd52);
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

    // Map a character to {invalid, 6-bit value}.
    function automatic logic [SymW:0] dec_char(input logic [ByteW-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            return {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            return {1'b0, 6'd62};
        end else if (c == 8'h2F) begin
            return {1'b0, 6'd63};
        end else begin
            return {1'b1, 6'd0};
        end
    endfunction

    // Space, tab, line feed, vertical tab, form feed and carriage return.
    function automatic logic is_space(input logic [ByteW-1:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

/* rtl/core/base64_stream_codec_unit.sv */
// ----------------------------------------------------------------------------
// Base64 stream codec unit
// Streaming Base64 encoder and decoder with a single direction register.
// ----------------------------------------------------------------------------
// The unit registers each input word, works out all of its results in one
// pass, and places them in a three-entry result queue that presents one
// result word per cycle unless the output stalls. A word is taken every
// cycle while the output does not stall and each word yields at most one
// result; whitespace, pad, invalid or ignored characters yield none.
// Otherwise a word holds the input until its results have left: one or two
// for an encoded data byte, up to three for an encode finish, and one for
// a decoded byte, a decode finish or a finish after an invalid character.
// The direction register is written through i_cfg_we and must only change
// while the unit holds no pending work.
module base64_stream_codec_unit
    import b64sc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    // Configuration
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    // Input channel
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_word,
    // Output channel
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_word
);

    // Input register.
    logic r_in_vld;
    t_in  r_in;

    // Codec state.
    logic            r_dir;
    logic [AccW-1:0] r_acc;
    logic [CountW-1:0] r_bits;
    logic [1:0]      r_phase;
    logic            r_err;
    logic            r_pad;

    // Result queue.
    t_out       r_res [MaxRes];
    logic [1:0] r_cnt;

    // Next values.
    logic [AccW-1:0]   n_acc;
    logic [CountW-1:0] n_bits;
    logic [1:0]        n_phase;
    logic              n_err;
    logic              n_pad;
    t_out              n_res [MaxRes];
    logic [1:0]        n_cnt;

    // Handshake terms.
    logic w_take;
    logic w_free;
    logic w_process;

    // Encode data path.
    logic [AccW-1:0] w_enc_acc;
    logic [4:0]      w_enc_bits;
    logic [1:0]      w_enc_n;
    logic [4:0]      w_enc_rem;
    logic [ByteW-1:0] w_enc_chr [MaxRes];

    // Decode data path.
    logic [SymW:0]    w_dec_code;
    logic [AccW-1:0]  w_dec_acc;
    logic [4:0]       w_dec_bits;
    logic [1:0]       w_dec_n;
    logic [4:0]       w_dec_rem;
    logic [ByteW-1:0] w_dec_byte [2];

    // Finish path.
    logic [AccW-1:0]  w_trail_mask;
    logic             w_trail_bad;
    logic             w_flush;
    logic [19:0]      w_flush_wide;
    logic [ByteW-1:0] w_flush_chr;
    logic [1:0]       w_fin_phase;
    logic [1:0]       w_pad_cnt;
    logic [2:0]       w_fin_total;
    logic [1:0]       w_fin_n;

    // Handshake: the queue is free when empty or when its last word leaves now.
    assign w_take      = o_out_valid && !i_out_stall;
    assign w_free      = (r_cnt == 2'd0) || (r_cnt == 2'd1 && w_take);
    assign w_process   = r_in_vld && w_free;
    assign o_in_stall  = r_in_vld && !w_free;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_word  = r_res[0];

    // Encode: append the byte and cut whole symbols from the top.
    assign w_enc_acc  = {r_acc[AccW-ByteW-1:0], r_in.data_byte};
    assign w_enc_bits = {1'b0, r_bits} + 5'd8;
    always_comb begin
        if (w_enc_bits >= 5'd18) begin
            w_enc_n = 2'd3;
        end else if (w_enc_bits >= 5'd12) begin
            w_enc_n = 2'd2;
        end else begin
            w_enc_n = 2'd1;
        end
    end
    assign w_enc_rem    = w_enc_bits - ({3'b000, w_enc_n} * 5'd6);
    assign w_enc_chr[0] = enc_char(SymW'(w_enc_acc >> (w_enc_bits - 5'd6)));
    assign w_enc_chr[1] = enc_char(SymW'(w_enc_acc >> (w_enc_bits - 5'd12)));
    assign w_enc_chr[2] = enc_char(SymW'(w_enc_acc >> (w_enc_bits - 5'd18)));

    // Decode: append the symbol value and cut whole bytes from the top.
    assign w_dec_code = dec_char(r_in.data_byte);
    assign w_dec_acc  = {r_acc[AccW-SymW-1:0], w_dec_code[SymW-1:0]};
    assign w_dec_bits = {1'b0, r_bits} + 5'd6;
    always_comb begin
        if (w_dec_bits >= 5'd16) begin
            w_dec_n = 2'd2;
        end else if (w_dec_bits >= 5'd8) begin
            w_dec_n = 2'd1;
        end else begin
            w_dec_n = 2'd0;
        end
    end
    assign w_dec_rem     = w_dec_bits - {w_dec_n, 3'b000};
    assign w_dec_byte[0] = ByteW'(w_dec_acc >> (w_dec_bits - 5'd8));
    assign w_dec_byte[1] = ByteW'(w_dec_acc >> (w_dec_bits - 5'd16));

    // Decode finish: leftover low bits must be zero.
    assign w_trail_mask = ~({AccW{1'b1}} << r_bits);
    assign w_trail_bad  = |(r_acc & w_trail_mask);

    // Encode finish: zero-fill the partial symbol, then pad to four.
    assign w_flush      = (r_bits != '0);
    assign w_flush_wide = {r_acc, 6'b000000} >> r_bits;
    assign w_flush_chr  = enc_char(w_flush_wide[SymW-1:0]);
    assign w_fin_phase  = r_phase + {1'b0, w_flush};
    assign w_pad_cnt    = 2'(~w_fin_phase + 2'd1);
    assign w_fin_total  = {2'b00, w_flush} + {1'b0, w_pad_cnt};
    assign w_fin_n      = (w_fin_total >= 3'd3) ? 2'd3 : w_fin_total[1:0];

    // Result and next-state selection for the word in the input register.
    always_comb begin
        n_acc   = r_acc;
        n_bits  = r_bits;
        n_phase = r_phase;
        n_err   = r_err;
        n_pad   = r_pad;
        n_cnt   = 2'd0;
        for (int k = 0; k < MaxRes; k++) begin
            n_res[k] = '0;
        end

        if (r_in.func == FUNC_DATA) begin
            if (!r_err) begin
                if (r_dir == DIR_DECODE) begin
                    if (!(r_pad || is_space(r_in.data_byte))) begin
                        priority if (r_in.data_byte == CHAR_PAD) begin
                            n_pad = 1'b1;
                        end else if (w_dec_code[SymW]) begin
                            n_err = 1'b1;
                        end else begin
                            n_acc    = w_dec_acc;
                            n_bits   = w_dec_rem[CountW-1:0];
                            n_cnt    = w_dec_n;
                            n_res[0] = '{out_byte: w_dec_byte[0], has_byte: 1'b1,
                                         last: (w_dec_n == 2'd1), status: ST_OK};
                            n_res[1] = '{out_byte: w_dec_byte[1], has_byte: 1'b1,
                                         last: 1'b1, status: ST_OK};
                        end
                    end
                end else begin
                    n_acc   = w_enc_acc;
                    n_bits  = w_enc_rem[CountW-1:0];
                    n_phase = r_phase + w_enc_n;
                    n_cnt   = w_enc_n;
                    for (int k = 0; k < MaxRes; k++) begin
                        n_res[k] = '{out_byte: w_enc_chr[k], has_byte: 1'b1,
                                     last: (w_enc_n == 2'(k + 1)), status: ST_OK};
                    end
                end
            end
        end else begin
            // Finish always answers and then clears the codec state.
            n_acc   = '0;
            n_bits  = '0;
            n_phase = '0;
            n_err   = 1'b0;
            n_pad   = 1'b0;
            n_cnt   = 2'd1;
            priority if (r_err) begin
                n_res[0] = '{out_byte: '0, has_byte: 1'b0, last: 1'b1,
                             status: ST_BAD_CHAR};
            end else if (r_dir == DIR_DECODE) begin
                n_res[0] = '{out_byte: '0, has_byte: 1'b0, last: 1'b1,
                             status: (w_trail_bad ? ST_TRAIL : ST_OK)};
            end else if (w_fin_n == 2'd0) begin
                n_res[0] = '{out_byte: '0, has_byte: 1'b0, last: 1'b1,
                             status: ST_OK};
            end else begin
                n_cnt = w_fin_n;
                for (int k = 0; k < MaxRes; k++) begin
                    n_res[k] = '{out_byte: CHAR_PAD, has_byte: 1'b1,
                                 last: (w_fin_n == 2'(k + 1)), status: ST_OK};
                end
                if (w_flush) begin
                    n_res[0].out_byte = w_flush_chr;
                end
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_dir    <= DIR_ENCODE;
            r_acc    <= '0;
            r_bits   <= '0;
            r_phase  <= '0;
            r_err    <= 1'b0;
            r_pad    <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_dir <= i_cfg_wdata;
            end
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (w_process) begin
                r_acc   <= n_acc;
                r_bits  <= n_bits;
                r_phase <= n_phase;
                r_err   <= n_err;
                r_pad   <= n_pad;
                r_cnt   <= n_cnt;
            end else if (w_take) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Payload registers: input word and result queue.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
        if (w_process) begin
            for (int k = 0; k < MaxRes; k++) begin
                r_res[k] <= n_res[k];
            end
        end else if (w_take) begin
            for (int k = 0; k < MaxRes - 1; k++) begin
                r_res[k] <= r_res[k + 1];
            end
        end
    end

`ifndef SYNTHESIS
    // The last flag shows only on the final queued result of a word.
    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.last) |-> (r_cnt == 2'd1))
        else $error("last flag shown while more results are queued");

    // A finish leaves the codec state cleared.
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_process && r_in.func == FUNC_FINISH) |=>
        (r_bits == '0 && r_phase == '0 && !r_err && !r_pad))
        else $error("codec state not cleared after finish");

    // Held bit count never reaches a whole byte.
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_bits[3])
        else $error("held bit count out of range");
`endif

endmodule
